FILE: rtl/core/kpq_pkg.sv
// Package for the key press qualifier: sizes, request codes, register indexes
// and the control bundle that the top level sends to each key cell.
// No dependencies.
package kpq_pkg;

    localparam int NUM_KEYS    = 3;
    localparam int COUNT_WIDTH = 16;
    localparam int THR_W       = 16;
    localparam int KEY_IDX_W   = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int CMP_W       = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    localparam logic [KEY_IDX_W-1:0] LAST_KEY   = KEY_IDX_W'(NUM_KEYS - 1);
    localparam logic [THR_W-1:0]     THR_RESET  = THR_W'(100);

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_REPEAT_MASK = 1'b0;
    localparam logic REG_HOLD_THR    = 1'b1;

    typedef struct packed {
        logic tick;       // tick request being applied this cycle
        logic pin_low;    // key pin sampled low
        logic repeat_en;  // auto-repeat enabled for this key
        logic clear;      // check request clears the latch
    } kpq_cell_ctrl_t;

endpackage

FILE: rtl/core/kpq_if.sv
// Valid/ready channel interfaces for the key press qualifier: requests in,
// results out. Depends on kpq_pkg.
interface kpq_req_if
    import kpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [NUM_KEYS-1:0]  pin_levels;
    logic [KEY_IDX_W-1:0] key_index;

    modport source (output valid, output req_type, output pin_levels, output key_index,
                    input ready);
    modport sink   (input valid, input req_type, input pin_levels, input key_index,
                    output ready);
endinterface

interface kpq_rsp_if;
    logic valid;
    logic ready;
    logic key_pressed;

    modport source (output valid, output key_pressed, input ready);
    modport sink   (input valid, input key_pressed, output ready);
endinterface

FILE: rtl/core/kpq_key_cell.sv
// State of one key: saturating hold counter, repeat lock and press latch.
// Depends on kpq_pkg.
module kpq_key_cell
    import kpq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kpq_cell_ctrl_t       ctrl,
    input  logic [THR_W-1:0]     threshold,
    output logic                 latch
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic                   lock_reg, lock_next;
    logic                   latch_reg, latch_next;
    logic                   over;

    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign over      = CMP_W'(count_inc) > CMP_W'(threshold);

    always_comb
    begin
        count_next = count_reg;
        lock_next  = lock_reg;
        latch_next = latch_reg;
        if (ctrl.tick)
        begin
            if (ctrl.pin_low)
            begin
                count_next = count_inc;
                if (over)
                begin
                    if (ctrl.repeat_en)
                    begin
                        latch_next = 1'b1;
                        count_next = '0;
                    end
                    else if (!lock_reg)
                    begin
                        lock_next  = 1'b1;
                        latch_next = 1'b1;
                    end
                end
            end
            else
            begin
                count_next = '0;
                lock_next  = 1'b0;
            end
        end
        else if (ctrl.clear)
        begin
            latch_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lock_reg  <= 1'b0;
            latch_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            lock_reg  <= lock_next;
            latch_reg <= latch_next;
        end
    end

    assign latch = latch_reg;

endmodule

FILE: rtl/core/key_press_qualifier_autorepeat.sv
// Key press qualifier with auto-repeat for three active-low keys.
// Path: an accepted check passes the request register, then the result register;
// a tick gives no result.
// Throughput: one request per cycle; only a waiting check stalls the request stage.
// Reset (rst_n, async, active low): counters, locks, latches and valids clear,
// repeat mask resets to 0 and hold threshold to 100.
module key_press_qualifier_autorepeat
    import kpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    kpq_req_if.sink               req,
    kpq_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------------------------------------------------------
    // Configuration registers. Register index is paddr[2]; the low
    // address bits are not decoded.
    // ---------------------------------------------------------------
    logic [NUM_KEYS-1:0] repeat_mask_reg;
    logic [THR_W-1:0]    thr_reg;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mask_reg <= '0;
            thr_reg         <= THR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_REPEAT_MASK: repeat_mask_reg <= pwdata[NUM_KEYS-1:0];
                REG_HOLD_THR:    thr_reg         <= pwdata[THR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_REPEAT_MASK: prdata = APB_DATA_W'(repeat_mask_reg);
            REG_HOLD_THR:    prdata = APB_DATA_W'(thr_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Request register. Hold it while a check cannot hand its result
    // to a full, stalled result register; advance otherwise.
    // ---------------------------------------------------------------
    logic                 req_valid_reg;
    logic                 req_type_reg;
    logic [NUM_KEYS-1:0]  pin_reg;
    logic [KEY_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    logic                 out_data_reg;
    logic                 advance;
    logic                 take;

    assign advance   = req_valid_reg &&
                       (req_type_reg == REQ_TICK || !out_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_type_reg <= req.req_type;
            pin_reg      <= req.pin_levels;
            idx_reg      <= req.key_index;
        end
    end

    // ---------------------------------------------------------------
    // Key cells. A tick updates every key; a check clears only the
    // named key, and an index beyond the last key touches nothing.
    // ---------------------------------------------------------------
    logic [NUM_KEYS-1:0] latch_vec;
    logic                idx_ok;
    logic                do_tick;
    logic                do_check;

    assign idx_ok   = idx_reg <= LAST_KEY;
    assign do_tick  = advance && req_type_reg == REQ_TICK;
    assign do_check = advance && req_type_reg == REQ_CHECK;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_key
        kpq_cell_ctrl_t ctrl;

        assign ctrl.tick      = do_tick;
        assign ctrl.pin_low   = !pin_reg[k];
        assign ctrl.repeat_en = repeat_mask_reg[k];
        assign ctrl.clear     = do_check && idx_ok && idx_reg == KEY_IDX_W'(k);

        kpq_key_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .threshold (thr_reg),
            .latch     (latch_vec[k])
        );
    end

    // ---------------------------------------------------------------
    // Result register: the latch value before clearing, 0 for a bad index.
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (do_check)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_check)
        begin
            out_data_reg <= idx_ok ? latch_vec[idx_reg] : 1'b0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.key_pressed = out_data_reg;

endmodule

FILE: rtl/core/kpq_checker.sv
// Port-level assertions for the key press qualifier, bound to the top level.
// Depends on kpq_pkg and key_press_qualifier_autorepeat.
module kpq_checker
    import kpq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_type,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_key_pressed
);

    // a waiting result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a waiting result keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_key_pressed))
        else $error("result changed while stalled");

    // a new result comes only from an accepted check request
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && req_type == REQ_CHECK, 2))
        else $error("result without a check request");

    // no result right out of reset
    a_rst_quiet: assert property (@(posedge clk)
        $past(!rst_n) |-> !rsp_valid)
        else $error("result valid after reset");

endmodule

bind key_press_qualifier_autorepeat kpq_checker u_kpq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_type        (req.req_type),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_key_pressed (rsp.key_pressed)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for key_press_qualifier_autorepeat: drives tick and check requests,
// programs both registers over APB and compares each check result with a local predictor.
// Depends on kpq_pkg, the kpq_req_if / kpq_rsp_if interfaces and the block itself.
module tb_top;
    import kpq_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    // A check answers through the request and result registers; leave some margin on top.
    localparam int DRAIN_CYCLES    = 6;
    // Longest correct quiet spell is the result hold-off below, so this is far above it.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_REQUESTS  = 80;
    localparam int NUM_PHASES      = 6;
    localparam int LONG_HOLD_TICKS = 120;

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;
    localparam logic [THR_W-1:0]       THR_TOP   = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    kpq_req_if req_ch();
    kpq_rsp_if rsp_ch();

    key_press_qualifier_autorepeat dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow copy of the registers and of each key's
    // hold counter, repeat lock and press latch.
    // ------------------------------------------------------------------
    logic [NUM_KEYS-1:0]    repeat_mask_cfg;
    logic [THR_W-1:0]       hold_limit_cfg;
    logic [COUNT_WIDTH-1:0] hold_ticks [NUM_KEYS];
    logic                   press_lock [NUM_KEYS];
    logic                   press_flag [NUM_KEYS];

    // Latch values that the block owes us, oldest first.
    logic expected_presses [$];

    int errors;
    int requests_sent;
    int checks_compared;
    int presses_seen;
    int quiet_cycles;
    int send_idle_pct;
    int rsp_stall_pct;
    bit hold_off_pending;

    // Pin levels of the well-formed random holds; each key toggles now and then.
    logic [NUM_KEYS-1:0] pin_track;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
    endtask

    // Advance the shadow state by one accepted request and queue the result a
    // check owes. Ticks never produce a result.
    function automatic void qualify_request(logic rtype, logic [NUM_KEYS-1:0] pins,
                                            logic [KEY_IDX_W-1:0] idx);
        if (rtype == REQ_TICK)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (pins[k])
                begin
                    // released: drop both counter and lock
                    hold_ticks[k] = '0;
                    press_lock[k] = 1'b0;
                end
                else
                begin
                    // held low: count up, but saturate instead of wrapping
                    if (hold_ticks[k] != COUNT_TOP)
                        hold_ticks[k] = hold_ticks[k] + 1'b1;
                    if (hold_ticks[k] > hold_limit_cfg)
                    begin
                        if (repeat_mask_cfg[k])
                        begin
                            // auto-repeat ignores the lock and restarts the count
                            press_flag[k] = 1'b1;
                            hold_ticks[k] = '0;
                        end
                        else if (!press_lock[k])
                        begin
                            press_lock[k] = 1'b1;
                            press_flag[k] = 1'b1;
                        end
                    end
                end
            end
        end
        else if (idx < NUM_KEYS)
        begin
            expected_presses.push_back(press_flag[idx]);
            press_flag[idx] = 1'b0;
        end
        else
        begin
            // out-of-range key: no state change, answer is zero
            expected_presses.push_back(1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side. valid stays high after an accept so back-to-back
    // requests never lower and raise it in the same step; an idle gap
    // drops it first.
    // ------------------------------------------------------------------
    task automatic send_request(logic rtype, logic [NUM_KEYS-1:0] pins,
                                logic [KEY_IDX_W-1:0] idx);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rtype;
        req_ch.pin_levels <= pins;
        req_ch.key_index  <= idx;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        qualify_request(rtype, pins, idx);
        requests_sent++;
    endtask

    // Tick with a random key index, which the block must ignore.
    task automatic send_tick(logic [NUM_KEYS-1:0] pins);
        send_request(REQ_TICK, pins, KEY_IDX_W'($urandom));
    endtask

    // Check with random pin levels, which the block must ignore.
    task automatic send_check(logic [KEY_IDX_W-1:0] idx);
        send_request(REQ_CHECK, NUM_KEYS'($urandom), idx);
    endtask

    // Mostly well-formed holds with random length, some raw noise, and checks
    // on every key including the one past the end.
    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            if ($urandom_range(0, 9) == 0)
                send_check(KEY_IDX_W'(NUM_KEYS));
            else
                send_check(KEY_IDX_W'($urandom_range(0, NUM_KEYS - 1)));
        end
        else if (pick < 40)
            send_tick(NUM_KEYS'($urandom));
        else
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 99) < 12)
                    pin_track[k] = ~pin_track[k];
            send_tick(pin_track);
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty out
    // behind any trailing ticks before the registers are touched.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (expected_presses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB: setup cycle, access cycle, then psel drops again.
    // ------------------------------------------------------------------
    task automatic apb_transfer(logic write, logic reg_idx, logic [APB_DATA_W-1:0] wdata,
                                output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= APB_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(logic reg_idx, logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] readback;
        apb_transfer(1'b0, reg_idx, '0, readback);
        if (readback !== want)
            report_mismatch(reg_idx == REG_HOLD_THR ? "hold threshold readback"
                                                    : "repeat mask readback", readback, want);
    endtask

    task automatic write_register(logic reg_idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused;
        apb_transfer(1'b1, reg_idx, value, unused);
        if (reg_idx == REG_REPEAT_MASK)
        begin
            repeat_mask_cfg = value[NUM_KEYS-1:0];
            check_register(reg_idx, APB_DATA_W'(repeat_mask_cfg));
        end
        else
        begin
            hold_limit_cfg = value[THR_W-1:0];
            check_register(reg_idx, APB_DATA_W'(hold_limit_cfg));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready toggles at random; on request it holds off for a
    // long stretch so the block fills up and stalls its request input.
    // ------------------------------------------------------------------
    initial
    begin : result_receiver
        int held;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending)
            begin
                rsp_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_OFF_CYCLES)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_off_pending = 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // Compare every accepted result with the oldest owed latch value.
    always @(posedge clk)
    begin : check_results
        logic want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_presses.size() == 0)
                report_mismatch("result with no check pending", 32'(rsp_ch.key_pressed), 0);
            else
            begin
                want = expected_presses.pop_front();
                if (rsp_ch.key_pressed !== want)
                    report_mismatch("key_pressed", 32'(rsp_ch.key_pressed), 32'(want));
                checks_compared++;
                if (want)
                    presses_seen++;
            end
        end
    end

    // Stop a hung run: count cycles in which no handshake of any kind completes.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable && pready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results still owed",
                         quiet_cycles, expected_presses.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Both registers read back their reset values.
    task automatic test_register_reset();
        check_register(REG_REPEAT_MASK, '0);
        check_register(REG_HOLD_THR, APB_DATA_W'(THR_RESET));
    endtask

    // Press, lock, release and clear-on-check with a short threshold.
    task automatic test_press_and_release();
        write_register(REG_HOLD_THR, 2);
        write_register(REG_REPEAT_MASK, 0);
        send_tick('1);
        for (int k = 0; k <= NUM_KEYS; k++)
            send_check(KEY_IDX_W'(k));
        // up held three ticks: third tick exceeds the threshold
        repeat (3) send_tick(3'b110);
        // all held: up stays locked, down and enter register
        repeat (3) send_tick(3'b000);
        for (int k = 0; k < NUM_KEYS; k++)
            send_check(KEY_IDX_W'(k));
        send_check(KEY_IDX_W'(0));
        send_tick(3'b000);
        send_check(KEY_IDX_W'(1));
        send_tick('1);
        send_check(KEY_IDX_W'(NUM_KEYS));
        settle_block();
    endtask

    // Threshold zero, and repeat switched on while a key is locked.
    task automatic test_threshold_corners();
        write_register(REG_HOLD_THR, 0);
        repeat (2) send_tick(3'b011);
        repeat (2) send_check(KEY_IDX_W'(2));
        send_tick('1);
        settle_block();
        write_register(REG_HOLD_THR, 2);
        repeat (3) send_tick(3'b101);
        send_check(KEY_IDX_W'(1));
        settle_block();
        // lock is set; with repeat on it no longer blocks
        write_register(REG_REPEAT_MASK, 3'b010);
        repeat (3) send_tick(3'b101);
        send_check(KEY_IDX_W'(1));
        repeat (4) send_tick(3'b101);
        send_check(KEY_IDX_W'(1));
        send_tick('1);
        settle_block();
    endtask

    // An all-ones threshold never registers a press over a long hold; then drop
    // the threshold just below the running count so the next held tick exceeds it.
    task automatic test_threshold_top();
        write_register(REG_REPEAT_MASK, 0);
        write_register(REG_HOLD_THR, APB_DATA_W'(THR_TOP));
        repeat (LONG_HOLD_TICKS) send_tick(3'b011);
        send_check(KEY_IDX_W'(2));
        settle_block();
        write_register(REG_HOLD_THR, APB_DATA_W'(LONG_HOLD_TICKS - 1));
        send_tick(3'b011);
        send_check(KEY_IDX_W'(2));
        send_tick('1);
        settle_block();
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_random_traffic();
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_block();
            case (phase)
                0:
                begin
                    write_register(REG_REPEAT_MASK, 0);
                    write_register(REG_HOLD_THR, 1);
                end
                1:
                begin
                    write_register(REG_REPEAT_MASK, 3'b111);
                    write_register(REG_HOLD_THR, 1);
                end
                2:
                begin
                    write_register(REG_REPEAT_MASK, 3'b101);
                    write_register(REG_HOLD_THR, 4);
                end
                3:
                begin
                    write_register(REG_REPEAT_MASK, NUM_KEYS'($urandom));
                    write_register(REG_HOLD_THR, 0);
                end
                4:
                begin
                    write_register(REG_REPEAT_MASK, NUM_KEYS'($urandom));
                    write_register(REG_HOLD_THR, $urandom_range(1, 12));
                end
                default:
                begin
                    write_register(REG_REPEAT_MASK, 3'b010);
                    write_register(REG_HOLD_THR, APB_DATA_W'(THR_TOP - 1'b1));
                end
            endcase
            // one full phase without any idling on either side
            send_idle_pct = (phase == 1) ? 0 : 21;
            rsp_stall_pct = (phase == 1) ? 0 : 21;
            repeat (PHASE_REQUESTS) send_random_request();
        end
        send_idle_pct = 21;
        rsp_stall_pct = 21;
        settle_block();
    endtask

    // Keep offering requests while results are held off for a long stretch.
    task automatic test_result_backpressure();
        write_register(REG_REPEAT_MASK, 3'b111);
        write_register(REG_HOLD_THR, 1);
        hold_off_pending = 1'b1;
        repeat (60) send_random_request();
        settle_block();
    endtask

    initial
    begin
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_TICK;
        req_ch.pin_levels = '1;
        req_ch.key_index  = '0;

        repeat_mask_cfg = '0;
        hold_limit_cfg  = THR_RESET;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            hold_ticks[k] = '0;
            press_lock[k] = 1'b0;
            press_flag[k] = 1'b0;
        end
        errors           = 0;
        requests_sent    = 0;
        checks_compared  = 0;
        presses_seen     = 0;
        quiet_cycles     = 0;
        send_idle_pct    = 21;
        rsp_stall_pct    = 21;
        hold_off_pending = 1'b0;
        pin_track        = '1;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_press_and_release();
        test_threshold_corners();
        test_threshold_top();
        test_random_traffic();
        test_result_backpressure();
        settle_block();

        $display("Sent %0d requests; compared %0d check results, %0d of them presses.",
                 requests_sent, checks_compared, presses_seen);
        $display("Thresholds zero to all ones, repeat masks off to all on, %s",
                 "long holds and a long result stall.");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
